@@ design/checked_integer_power_macros.svh @@
// Assertion macros shared by the checked integer power design.
`ifndef CHECKED_INTEGER_POWER_MACROS_SVH
`define CHECKED_INTEGER_POWER_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define CIP_ASSERT_SAME(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error("checked_integer_power: same-cycle check failed");

// Property that must hold in the cycle after its trigger.
`define CIP_ASSERT_NEXT(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error("checked_integer_power: next-cycle check failed");

`endif

@@ design/cip_pkg.sv @@
// Package with widths and shared types of the checked integer power block.
package cip_pkg;

	// Default operand widths.
	localparam int CIP_VALUE_WIDTH    = 64;
	localparam int CIP_EXPONENT_WIDTH = 32;

	// Status returned by the shared multiplier.
	typedef struct packed {
		logic done;
		logic ovf;
	} cip_mul_rsp_t;

endpackage

@@ design/cip_mul.sv @@
// Shared multiplier that forms a full product from four half-width partial products.
module cip_mul import cip_pkg::*; #(
	parameter int VALUE_WIDTH = CIP_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output cip_mul_rsp_t           rsp,
	output logic [VALUE_WIDTH-1:0] prod
);

	localparam int HALF = (VALUE_WIDTH + 1) / 2;
	localparam int PW   = 2 * HALF;
	localparam int SW   = 2 * VALUE_WIDTH;

	localparam logic [2:0] STEP_LAST = 3'd4;

	logic                   busy_q;
	logic                   done_q;
	logic [2:0]             stp_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [PW-1:0]          pp_q;
	logic [SW-1:0]          sum_q;

	logic [HALF-1:0] a_lo;
	logic [HALF-1:0] a_hi;
	logic [HALF-1:0] b_lo;
	logic [HALF-1:0] b_hi;
	logic [HALF-1:0] op_x;
	logic [HALF-1:0] op_y;
	logic [PW-1:0]   pp_next;
	logic [SW-1:0]   pp_ext;
	logic [SW-1:0]   pp_shifted;

	// Split the operands into halves and pick the pair for this step.
	assign a_lo = a_q[HALF-1:0];
	assign b_lo = b_q[HALF-1:0];
	assign a_hi = HALF'(a_q >> HALF);
	assign b_hi = HALF'(b_q >> HALF);
	assign op_x = stp_q[1] ? a_hi : a_lo;
	assign op_y = stp_q[0] ? b_hi : b_lo;
	assign pp_next = PW'(op_x) * PW'(op_y);

	// Align the partial product registered in the previous step.
	assign pp_ext = SW'(pp_q);
	always_comb begin
		case (stp_q)
			3'd1:    pp_shifted = pp_ext;
			3'd2:    pp_shifted = pp_ext << HALF;
			3'd3:    pp_shifted = pp_ext << HALF;
			3'd4:    pp_shifted = pp_ext << PW;
			default: pp_shifted = '0;
		endcase
	end

	// Step sequencer of the multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			stp_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				stp_q  <= '0;
			end else if (busy_q) begin
				if (stp_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					stp_q <= stp_q + 3'd1;
				end
			end
		end
	end

	// Operand, partial product and running sum registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sum_q <= '0;
		end else if (busy_q) begin
			pp_q  <= pp_next;
			sum_q <= sum_q + pp_shifted;
		end
	end

	// The product overflows when any bit above the low half is set.
	assign prod     = sum_q[VALUE_WIDTH-1:0];
	assign rsp.done = done_q;
	assign rsp.ovf  = |sum_q[SW-1:VALUE_WIDTH];

endmodule

@@ design/checked_integer_power.sv @@
// Top level of the checked integer power block: sequencer around one shared multiplier.
// Raises base to exponent by right-to-left square-and-multiply and flags overflow when any
// needed product passes VALUE_WIDTH bits (power is then 0). Exponent 0 gives 1. One request
// is worked on at a time: req_stall is high from acceptance until the result is written to
// the output register, which holds it while res_stall is high, so a new request can be taken
// while the previous result still waits. Each multiplication runs on the shared unit as four
// half-width partial products with one registered add behind each. The next request can be
// accepted in the cycle after the result is loaded. Overflow ends the work early.
`include "checked_integer_power_macros.svh"

module checked_integer_power import cip_pkg::*; #(
	parameter int VALUE_WIDTH    = CIP_VALUE_WIDTH,
	parameter int EXPONENT_WIDTH = CIP_EXPONENT_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [VALUE_WIDTH-1:0]    base,
	input  logic [EXPONENT_WIDTH-1:0] exponent,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [VALUE_WIDTH-1:0]    power,
	output logic                      overflow
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		MUL_WAIT,
		SHIFT,
		SQR_WAIT,
		FINISH
	} state_t;

	state_t                    state_q;
	logic [VALUE_WIDTH-1:0]    acc_q;
	logic [VALUE_WIDTH-1:0]    fac_q;
	logic [EXPONENT_WIDTH-1:0] exp_q;
	logic                      ovf_q;
	logic                      res_valid_q;
	logic [VALUE_WIDTH-1:0]    power_q;
	logic                      overflow_q;

	logic                      req_take;
	logic                      exp_more;
	logic                      mul_start;
	logic [VALUE_WIDTH-1:0]    mul_a;
	cip_mul_rsp_t              mul_rsp;
	logic [VALUE_WIDTH-1:0]    mul_prod;

	// Request handshake and multiplier launch conditions.
	assign req_stall = (state_q != IDLE);
	assign req_take  = req_valid && !req_stall;
	assign exp_more  = (exp_q >> 1) != '0;
	assign mul_start = ((state_q == CHECK) && exp_q[0]) || ((state_q == SHIFT) && exp_more);
	assign mul_a     = (state_q == SHIFT) ? fac_q : acc_q;

	cip_mul #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (fac_q),
		.rsp   (mul_rsp),
		.prod  (mul_prod)
	);

	// Sequencer with the working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			acc_q       <= '0;
			fac_q       <= '0;
			exp_q       <= '0;
			power_q     <= '0;
			overflow_q  <= 1'b0;
		end else begin
			// A result taken outside the finish step leaves the output register empty.
			if (res_valid_q && !res_stall && (state_q != FINISH)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_take) begin
						fac_q   <= base;
						exp_q   <= exponent;
						acc_q   <= VALUE_WIDTH'(1);
						ovf_q   <= 1'b0;
						state_q <= CHECK;
					end
				end
				CHECK: begin
					if (exp_q == '0) begin
						state_q <= FINISH;
					end else if (exp_q[0]) begin
						state_q <= MUL_WAIT;
					end else begin
						state_q <= SHIFT;
					end
				end
				MUL_WAIT: begin
					if (mul_rsp.done) begin
						if (mul_rsp.ovf) begin
							ovf_q   <= 1'b1;
							state_q <= FINISH;
						end else begin
							acc_q   <= mul_prod;
							state_q <= SHIFT;
						end
					end
				end
				SHIFT: begin
					exp_q <= exp_q >> 1;
					if (exp_more) begin
						state_q <= SQR_WAIT;
					end else begin
						state_q <= FINISH;
					end
				end
				SQR_WAIT: begin
					if (mul_rsp.done) begin
						if (mul_rsp.ovf) begin
							ovf_q   <= 1'b1;
							state_q <= FINISH;
						end else begin
							fac_q   <= mul_prod;
							state_q <= CHECK;
						end
					end
				end
				FINISH: begin
					if (!res_valid_q || !res_stall) begin
						power_q     <= ovf_q ? '0 : acc_q;
						overflow_q  <= ovf_q;
						res_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign power     = power_q;
	assign overflow  = overflow_q;

	// An overflow result always carries a zero power.
	`CIP_ASSERT_SAME(a_ovf_zero, res_valid && overflow, power == '0)
	// An accepted request starts with an exponent check.
	`CIP_ASSERT_NEXT(a_req_check, req_take, state_q == CHECK)
	// The multiplier only reports back while the sequencer waits for it.
	`CIP_ASSERT_SAME(a_mul_wait, mul_rsp.done, state_q == MUL_WAIT || state_q == SQR_WAIT)
	// Each shift step moves the exponent down by one bit.
	`CIP_ASSERT_NEXT(a_exp_shift, state_q == SHIFT, exp_q == ($past(exp_q) >> 1))

endmodule
